[design/scvp_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the S-curve planner.
package scvp_pkg;

   localparam int VEL_WIDTH_DEF   = 32;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam int TICK_W     = 16;
   localparam int TOL_W      = 31;
   localparam int SCALE_W    = 16;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_SCALE   = 2'd3;

   localparam logic [TICK_W-1:0]  ACCEL_TICKS_RST = 16'd10;
   localparam logic [TICK_W-1:0]  DECEL_TICKS_RST = 16'd10;
   localparam logic [TOL_W-1:0]   TOLERANCE_RST   = 31'd655;
   localparam logic [SCALE_W-1:0] YAW_SCALE_RST   = 16'd256;

   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = 2;
   localparam logic [AXIS_W-1:0] AXIS_X   = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_YAW = 2'd2;

   // Number of quotient bits of the ramp fraction (Q0.31).
   localparam int FRAC_W   = 31;
   localparam int ITER_W   = 5;
   localparam logic [ITER_W-1:0] ITER_LAST = 5'(FRAC_W - 1);

   localparam logic DIR_ACCEL = 1'b0;
   localparam logic DIR_DECEL = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_LOAD,
      OP_ENTER,
      OP_SETUP,
      OP_SNAP,
      OP_DIV,
      OP_SQUARE,
      OP_SHAPE,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_APPLY,
      OP_BAND,
      OP_STORE,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                dir;
      logic [AXIS_W-1:0]   axis;
   } cmd_type;

   typedef struct packed {
      logic below;
      logic above;
      logic snap;
      logic rsp_free;
   } status_type;

endpackage

[design/scvp_ctrl.sv]
// Sequencer of the S-curve planner: walks the axes and the ramp steps of each.
module scvp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  scvp_pkg::status_type  status,
   output scvp_pkg::cmd_type     cmd
);

   typedef enum logic [18:0] {
      S_IDLE   = 19'h00001,
      S_LOAD   = 19'h00002,
      S_TEST   = 19'h00004,
      S_ENTER  = 19'h00008,
      S_SETUP  = 19'h00010,
      S_CHECK  = 19'h00020,
      S_SNAP   = 19'h00040,
      S_DIV    = 19'h00080,
      S_SQUARE = 19'h00100,
      S_SHAPE  = 19'h00200,
      S_MUL_LO = 19'h00400,
      S_MUL_HI = 19'h00800,
      S_APPLY  = 19'h01000,
      S_BAND   = 19'h02000,
      S_STORE  = 19'h04000,
      S_DONE   = 19'h08000,
      S_SPARE0 = 19'h10000,
      S_SPARE1 = 19'h20000,
      S_SPARE2 = 19'h40000
   } state_type;

   state_type                       state_ff, state_in;
   logic [scvp_pkg::AXIS_W-1:0]     axis_ff, axis_in;
   logic                            dir_ff, dir_in;
   logic [scvp_pkg::ITER_W-1:0]     iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= scvp_pkg::AXIS_X;
         dir_ff   <= scvp_pkg::DIR_ACCEL;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         dir_ff   <= dir_in;
         iter_ff  <= iter_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      dir_in    = dir_ff;
      iter_in   = iter_ff;
      req_ready = 1'b0;
      cmd.op    = scvp_pkg::OP_NONE;
      cmd.dir   = dir_ff;
      cmd.axis  = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = scvp_pkg::OP_CAPTURE;
               axis_in  = scvp_pkg::AXIS_X;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.op   = scvp_pkg::OP_LOAD;
            dir_in   = scvp_pkg::DIR_ACCEL;
            state_in = S_TEST;
         end
         S_TEST: begin
            if ((dir_ff == scvp_pkg::DIR_ACCEL) ? status.below : status.above) begin
               state_in = S_ENTER;
            end else begin
               state_in = S_BAND;
            end
         end
         S_ENTER: begin
            cmd.op   = scvp_pkg::OP_ENTER;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.op   = scvp_pkg::OP_SETUP;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            iter_in  = '0;
            state_in = status.snap ? S_SNAP : S_DIV;
         end
         S_SNAP: begin
            cmd.op   = scvp_pkg::OP_SNAP;
            state_in = S_BAND;
         end
         S_DIV: begin
            cmd.op  = scvp_pkg::OP_DIV;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == scvp_pkg::ITER_LAST) begin
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.op   = scvp_pkg::OP_SQUARE;
            state_in = S_SHAPE;
         end
         S_SHAPE: begin
            cmd.op   = scvp_pkg::OP_SHAPE;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.op   = scvp_pkg::OP_MUL_LO;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.op   = scvp_pkg::OP_MUL_HI;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.op   = scvp_pkg::OP_APPLY;
            state_in = S_BAND;
         end
         S_BAND: begin
            cmd.op = scvp_pkg::OP_BAND;
            if (dir_ff == scvp_pkg::DIR_ACCEL) begin
               dir_in   = scvp_pkg::DIR_DECEL;
               state_in = S_TEST;
            end else begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.op = scvp_pkg::OP_STORE;
            if (axis_ff == scvp_pkg::AXIS_YAW) begin
               state_in = S_DONE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.op   = scvp_pkg::OP_PUBLISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[design/scvp_datapath.sv]
// Datapath of the S-curve planner: axis state, divider, shared multiplier, result registers.
module scvp_datapath #(
   parameter int VEL_WIDTH   = scvp_pkg::VEL_WIDTH_DEF,
   parameter int COUNT_WIDTH = scvp_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [scvp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scvp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic signed [VEL_WIDTH-1:0]         req_target_x,
   input  logic signed [VEL_WIDTH-1:0]         req_target_y,
   input  logic signed [VEL_WIDTH-1:0]         req_target_yaw,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [VEL_WIDTH-1:0]         rsp_vel_x,
   output logic signed [VEL_WIDTH-1:0]         rsp_vel_y,
   output logic signed [VEL_WIDTH-1:0]         rsp_vel_yaw,
   input  scvp_pkg::cmd_type                   cmd,
   output scvp_pkg::status_type                status
);

   localparam int VW = VEL_WIDTH;
   localparam int CW = COUNT_WIDTH;
   localparam int EW = ((VW > 32) ? VW : 32) + 2;
   localparam int MW = ((VW + 1) > 32) ? (VW + 1) : 32;
   localparam int HW = MW - 31;
   localparam int TW = CW + 10;
   localparam int RW = ((TW > 33) ? TW : 33) + 1;
   localparam int FW = scvp_pkg::FRAC_W;
   localparam logic [CW-1:0] CNT_MAX = '1;
   localparam logic [31:0]   ONE_Q31 = 32'h8000_0000;

   typedef struct packed {
      logic signed [VW-1:0] vel;
      logic signed [VW-1:0] org;
      logic signed [VW-1:0] prev;
      logic [CW-1:0]        acnt;
      logic [CW-1:0]        dcnt;
      logic                 aact;
      logic                 dact;
      logic                 aarm;
      logic                 darm;
   } axis_type;

   localparam axis_type AXIS_RST = '{vel: '0, org: '0, prev: '0, acnt: '0, dcnt: '0,
                                     aact: 1'b0, dact: 1'b0, aarm: 1'b1, darm: 1'b1};

   logic [scvp_pkg::TICK_W-1:0]  accel_ticks_ff, accel_ticks_in;
   logic [scvp_pkg::TICK_W-1:0]  decel_ticks_ff, decel_ticks_in;
   logic [scvp_pkg::TOL_W-1:0]   tolerance_ff, tolerance_in;
   logic [scvp_pkg::SCALE_W-1:0] yaw_scale_ff, yaw_scale_in;

   axis_type             ax_ff [scvp_pkg::NUM_AXES];
   axis_type             ax_in [scvp_pkg::NUM_AXES];
   axis_type             w_ff, w_in;
   logic signed [VW-1:0] tgt_ff, tgt_in;
   logic signed [VW-1:0] target_ff [scvp_pkg::NUM_AXES];
   logic signed [VW-1:0] target_in [scvp_pkg::NUM_AXES];
   logic signed [VW-1:0] res_ff [scvp_pkg::NUM_AXES];
   logic signed [VW-1:0] res_in [scvp_pkg::NUM_AXES];
   logic signed [VW-1:0] rsp_ff [scvp_pkg::NUM_AXES];
   logic signed [VW-1:0] rsp_in [scvp_pkg::NUM_AXES];
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] den_ff, den_in;
   logic [FW-1:0] q_ff, q_in;
   logic [63:0]   prod_ff, prod_in;
   logic [31:0]   f_ff, f_in;
   logic [MW-1:0] inc_ff, inc_in;

   logic signed [EW-1:0] v_e, t_e, tol_e;
   logic                 below, above;
   logic [CW-1:0]        cnt_sel, cnt_next;
   logic [scvp_pkg::TICK_W-1:0] ticks_sel;
   logic [31:0]          mul_a, mul_b, sq_op;
   logic [63:0]          mul_p;
   logic signed [VW:0]   diff;
   logic                 dneg;
   logic [MW-1:0]        mag;
   logic [HW-1:0]        mag_hi;
   logic [RW-1:0]        rem_sh;
   logic signed [MW:0]   sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ticks_ff <= scvp_pkg::ACCEL_TICKS_RST;
         decel_ticks_ff <= scvp_pkg::DECEL_TICKS_RST;
         tolerance_ff   <= scvp_pkg::TOLERANCE_RST;
         yaw_scale_ff   <= scvp_pkg::YAW_SCALE_RST;
         for (int i = 0; i < scvp_pkg::NUM_AXES; i++) begin
            ax_ff[i] <= AXIS_RST;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         accel_ticks_ff <= accel_ticks_in;
         decel_ticks_ff <= decel_ticks_in;
         tolerance_ff   <= tolerance_in;
         yaw_scale_ff   <= yaw_scale_in;
         ax_ff          <= ax_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      tgt_ff    <= tgt_in;
      target_ff <= target_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      q_ff      <= q_in;
      prod_ff   <= prod_in;
      f_ff      <= f_in;
      inc_ff    <= inc_in;
   end

   // Configuration writes.
   always_comb begin
      accel_ticks_in = accel_ticks_ff;
      decel_ticks_in = decel_ticks_ff;
      tolerance_in   = tolerance_ff;
      yaw_scale_in   = yaw_scale_ff;
      if (csr_we) begin
         unique case (csr_index)
            scvp_pkg::CSR_ACCEL_TICKS: accel_ticks_in = csr_wdata[scvp_pkg::TICK_W-1:0];
            scvp_pkg::CSR_DECEL_TICKS: decel_ticks_in = csr_wdata[scvp_pkg::TICK_W-1:0];
            scvp_pkg::CSR_TOLERANCE:   tolerance_in   = csr_wdata[scvp_pkg::TOL_W-1:0];
            scvp_pkg::CSR_YAW_SCALE:   yaw_scale_in   = csr_wdata[scvp_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Band comparisons against the working axis.
   always_comb begin
      v_e   = EW'(w_ff.vel);
      t_e   = EW'(tgt_ff);
      tol_e = $signed(EW'(tolerance_ff));
      below = v_e < (t_e - tol_e);
      above = v_e > (t_e + tol_e);
   end

   always_comb begin
      cnt_sel   = (cmd.dir == scvp_pkg::DIR_DECEL) ? w_ff.dcnt : w_ff.acnt;
      cnt_next  = (cnt_sel == CNT_MAX) ? CNT_MAX : cnt_sel + 1'b1;
      ticks_sel = (cmd.dir == scvp_pkg::DIR_DECEL) ? decel_ticks_ff : accel_ticks_ff;
      diff      = (VW+1)'(tgt_ff) - (VW+1)'(w_ff.org);
      dneg      = diff[VW];
      mag       = MW'(dneg ? -diff : diff);
      mag_hi    = mag[MW-1:31];
      // In the second half the curve mirrors on y = 1 - x.
      sq_op     = q_ff[FW-1] ? (ONE_Q31 - 32'(q_ff)) : 32'(q_ff);
      rem_sh    = rem_ff << 1;
      sum       = dneg ? ((MW+1)'(w_ff.org) - $signed({1'b0, inc_ff}))
                       : ((MW+1)'(w_ff.org) + $signed({1'b0, inc_ff}));
   end

   // Single shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         scvp_pkg::OP_SETUP: begin
            mul_a = 32'(ticks_sel);
            mul_b = 32'(yaw_scale_ff);
         end
         scvp_pkg::OP_SQUARE: begin
            mul_a = sq_op;
            mul_b = sq_op;
         end
         scvp_pkg::OP_MUL_LO: begin
            mul_a = {1'b0, mag[30:0]};
            mul_b = f_ff;
         end
         scvp_pkg::OP_MUL_HI: begin
            mul_a = 32'(mag_hi);
            mul_b = f_ff;
         end
         default: ;
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   always_comb begin
      ax_in        = ax_ff;
      w_in         = w_ff;
      tgt_in       = tgt_ff;
      target_in    = target_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      f_in         = f_ff;
      inc_in       = inc_ff;
      case (cmd.op)
         scvp_pkg::OP_CAPTURE: begin
            target_in[0] = req_target_x;
            target_in[1] = req_target_y;
            target_in[2] = req_target_yaw;
         end
         scvp_pkg::OP_LOAD: begin
            w_in   = ax_ff[cmd.axis];
            tgt_in = target_ff[cmd.axis];
            if (target_ff[cmd.axis] != ax_ff[cmd.axis].prev) begin
               w_in.aarm = 1'b1;
               w_in.darm = 1'b1;
            end
         end
         scvp_pkg::OP_ENTER: begin
            if (cmd.dir == scvp_pkg::DIR_ACCEL) begin
               w_in.aact = 1'b1;
               w_in.dact = 1'b0;
               w_in.dcnt = '0;
               if (w_ff.aarm) begin
                  w_in.org  = w_ff.vel;
                  w_in.aarm = 1'b0;
               end
            end else begin
               w_in.aact = 1'b0;
               w_in.dact = 1'b1;
               w_in.acnt = '0;
               if (w_ff.darm) begin
                  w_in.org  = w_ff.vel;
                  w_in.darm = 1'b0;
               end
            end
         end
         scvp_pkg::OP_SETUP: begin
            // The divider compares elapsed time with twice the half time, both in 1/1024 tick.
            rem_in = RW'(cnt_sel) << 10;
            q_in   = '0;
            if (cmd.axis == scvp_pkg::AXIS_YAW) begin
               den_in = RW'(mul_p) << 1;
            end else begin
               den_in = RW'(ticks_sel) << 9;
            end
         end
         scvp_pkg::OP_SNAP: begin
            w_in.vel = tgt_ff;
            w_in.org = tgt_ff;
            if (cmd.dir == scvp_pkg::DIR_ACCEL) begin
               w_in.acnt = cnt_next;
            end else begin
               w_in.dcnt = cnt_next;
            end
         end
         scvp_pkg::OP_DIV: begin
            if (rem_sh >= den_ff) begin
               rem_in = rem_sh - den_ff;
               q_in   = {q_ff[FW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               q_in   = {q_ff[FW-2:0], 1'b0};
            end
         end
         scvp_pkg::OP_SQUARE: begin
            prod_in = mul_p;
         end
         scvp_pkg::OP_SHAPE: begin
            if (q_ff[FW-1]) begin
               f_in = ONE_Q31 - 32'(prod_ff >> 30);
            end else begin
               f_in = 32'(prod_ff >> 30);
            end
         end
         scvp_pkg::OP_MUL_LO: begin
            prod_in = mul_p;
         end
         scvp_pkg::OP_MUL_HI: begin
            inc_in = MW'(mul_p) + MW'(prod_ff >> 31);
         end
         scvp_pkg::OP_APPLY: begin
            w_in.vel = VW'(sum);
            if (cmd.dir == scvp_pkg::DIR_ACCEL) begin
               w_in.acnt = cnt_next;
            end else begin
               w_in.dcnt = cnt_next;
            end
         end
         scvp_pkg::OP_BAND: begin
            if (((cmd.dir == scvp_pkg::DIR_ACCEL) ? w_ff.aact : w_ff.dact) && !below && !above) begin
               w_in.acnt = '0;
               w_in.dcnt = '0;
               w_in.vel  = tgt_ff;
            end
         end
         scvp_pkg::OP_STORE: begin
            ax_in[cmd.axis]      = w_ff;
            ax_in[cmd.axis].prev = tgt_ff;
            res_in[cmd.axis]     = w_ff.vel;
         end
         scvp_pkg::OP_PUBLISH: begin
            rsp_in       = res_ff;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.below    = below;
      status.above    = above;
      status.snap     = (den_ff == '0) || (rem_ff >= den_ff);
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_vel_x   = rsp_ff[0];
   assign rsp_vel_y   = rsp_ff[1];
   assign rsp_vel_yaw = rsp_ff[2];

endmodule

[design/s_curve_velocity_planner.sv]
// Top level of the three-axis jerk-limited S-curve velocity planner.
//
//   channel  | direction | handshake          | payload
//   req      | in        | req_valid/ready    | req_target_x, req_target_y, req_target_yaw
//   rsp      | out       | rsp_valid/ready    | rsp_vel_x, rsp_vel_y, rsp_vel_yaw
//   csr      | in        | csr_we             | csr_index, csr_wdata
//
// The three axes are processed in turn by one datapath. Every ramp direction an axis enters
// adds the enter, setup and check steps and then either a snap step or a restoring divider
// over the 31 quotient bits plus five multiply and apply steps on the shared multiplier.
// Reset is synchronous and restores the register defaults and all axis state at once.
// A new request is taken while the previous result waits in the output register; the finished
// result is held back only until that register is free.
module s_curve_velocity_planner #(
   parameter int VEL_WIDTH   = scvp_pkg::VEL_WIDTH_DEF,
   parameter int COUNT_WIDTH = scvp_pkg::COUNT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [scvp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scvp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [VEL_WIDTH-1:0]       req_target_x,
   input  logic signed [VEL_WIDTH-1:0]       req_target_y,
   input  logic signed [VEL_WIDTH-1:0]       req_target_yaw,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [VEL_WIDTH-1:0]       rsp_vel_x,
   output logic signed [VEL_WIDTH-1:0]       rsp_vel_y,
   output logic signed [VEL_WIDTH-1:0]       rsp_vel_yaw
);

   scvp_pkg::cmd_type    cmd;
   scvp_pkg::status_type status;

   scvp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scvp_datapath #(
      .VEL_WIDTH   (VEL_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .req_target_yaw (req_target_yaw),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_vel_x      (rsp_vel_x),
      .rsp_vel_y      (rsp_vel_y),
      .rsp_vel_yaw    (rsp_vel_yaw),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

[test/s_curve_velocity_planner_test.sv]
// Self-checking testbench of the three-axis S-curve velocity planner.
module s_curve_velocity_planner_test;

   localparam int VW         = scvp_pkg::VEL_WIDTH_DEF;
   localparam int CYCLE_CAP  = 2_000_000;
   localparam int SETTLE     = 300;
   localparam int ITEMS_EACH = 200;

   typedef struct {
      logic signed [VW-1:0] x, y, yaw;
   } vel_set_type;

   typedef struct {
      logic signed [VW-1:0] x, y, yaw;
      bit                   typed;
      logic signed [VW-1:0] ex, ey, eyaw;
   } directed_row_type;

   typedef struct {
      bit [15:0] accel, decel;
      bit [30:0] tol;
      bit [15:0] scale;
   } ramp_setting_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [scvp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [scvp_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic signed [VW-1:0]            req_target_x = '0;
   logic signed [VW-1:0]            req_target_y = '0;
   logic signed [VW-1:0]            req_target_yaw = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic signed [VW-1:0]            rsp_vel_x, rsp_vel_y, rsp_vel_yaw;

   s_curve_velocity_planner uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_yaw(req_target_yaw),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y), .rsp_vel_yaw(rsp_vel_yaw)
   );

   always #5 clock = ~clock;

   // Planner state mirror.
   bit [15:0]   accel_ticks_q, decel_ticks_q, yaw_scale_q;
   bit [30:0]   tol_q;
   longint      cur_vel[3], org_vel[3], last_tgt[3];
   longint unsigned up_cnt[3], down_cnt[3];
   bit          up_on[3], down_on[3], up_armed[3], down_armed[3];

   vel_set_type pending_vel[$];
   int          mismatches = 0;
   int          checked = 0;
   int          cycles = 0;
   bit          calm = 1'b0;

   function automatic void reset_planner();
      accel_ticks_q = scvp_pkg::ACCEL_TICKS_RST;
      decel_ticks_q = scvp_pkg::DECEL_TICKS_RST;
      tol_q         = scvp_pkg::TOLERANCE_RST;
      yaw_scale_q   = scvp_pkg::YAW_SCALE_RST;
      for (int i = 0; i < scvp_pkg::NUM_AXES; i++) begin
         cur_vel[i] = 0; org_vel[i] = 0; last_tgt[i] = 0;
         up_cnt[i] = 0; down_cnt[i] = 0;
         up_on[i] = 0; down_on[i] = 0;
         up_armed[i] = 1; down_armed[i] = 1;
      end
   endfunction

   function automatic longint unsigned half_ticks(int ax, bit [15:0] ticks);
      if (ax == int'(scvp_pkg::AXIS_YAW))
         return longint'(ticks) * longint'(yaw_scale_q);
      return longint'(ticks) << 8;
   endfunction

   // Position on the S-curve after cnt ticks of a ramp with half time h.
   function automatic longint curve_point(int ax, longint unsigned h,
                                          longint unsigned cnt, longint tgt);
      longint unsigned t, xf, yf, f, mag, inc;
      longint          d;
      t = cnt * 1024;
      d = tgt - org_vel[ax];
      if (h == 0 || t >= 2 * h) begin
         org_vel[ax] = tgt;
         return tgt;
      end
      xf = (t << 31) / (2 * h);
      if (t < h)
         f = (2 * xf * xf) >> 31;
      else begin
         yf = (64'd1 << 31) - xf;
         f = (64'd1 << 31) - ((2 * yf * yf) >> 31);
      end
      mag = (d < 0) ? longint'(-d) : longint'(d);
      inc = (mag >> 31) * f + (((mag & ((64'd1 << 31) - 1)) * f) >> 31);
      return (d < 0) ? org_vel[ax] - longint'(inc) : org_vel[ax] + longint'(inc);
   endfunction

   function automatic longint plan_axis(int i, longint tgt);
      longint tol, v;
      tol = longint'(tol_q);
      v = cur_vel[i];
      if (tgt != last_tgt[i]) begin
         up_armed[i] = 1; down_armed[i] = 1;
         last_tgt[i] = tgt;
      end
      if (v < tgt - tol) begin
         up_on[i] = 1; down_cnt[i] = 0; down_on[i] = 0;
         if (up_armed[i]) begin
            org_vel[i] = v; up_armed[i] = 0;
         end
         v = curve_point(i, half_ticks(i, accel_ticks_q), up_cnt[i], tgt);
         if (up_cnt[i] < 65535) up_cnt[i]++;
      end
      if (up_on[i] && v >= tgt - tol && v <= tgt + tol) begin
         up_cnt[i] = 0; down_cnt[i] = 0; v = tgt;
      end
      if (v > tgt + tol) begin
         up_on[i] = 0; down_on[i] = 1; up_cnt[i] = 0;
         if (down_armed[i]) begin
            org_vel[i] = v; down_armed[i] = 0;
         end
         v = curve_point(i, half_ticks(i, decel_ticks_q), down_cnt[i], tgt);
         if (down_cnt[i] < 65535) down_cnt[i]++;
      end
      if (down_on[i] && v <= tgt + tol && v >= tgt - tol) begin
         up_cnt[i] = 0; down_cnt[i] = 0; v = tgt;
      end
      cur_vel[i] = v;
      return v;
   endfunction

   function automatic vel_set_type plan_tick(vel_set_type tgt);
      vel_set_type r;
      r.x   = VW'(plan_axis(0, longint'(tgt.x)));
      r.y   = VW'(plan_axis(1, longint'(tgt.y)));
      r.yaw = VW'(plan_axis(2, longint'(tgt.yaw)));
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [VW-1:0] pick_target();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(VW-1){1'b1}}};
         1: return {1'b1, {(VW-1){1'b0}}};
         2, 3: return $urandom;
         4: return $urandom_range(0, 2000) - 1000;
         default: return $urandom_range(0, 2097152) - 1048576;
      endcase
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is accepted.
   task automatic send_targets(vel_set_type tgt, bit typed, vel_set_type typed_vel);
      int          gap;
      vel_set_type planned;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_target_x   <= tgt.x;
      req_target_y   <= tgt.y;
      req_target_yaw <= tgt.yaw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      planned = plan_tick(tgt);
      pending_vel.push_back(typed ? typed_vel : planned);
   endtask

   task automatic drain();
      while (pending_vel.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [scvp_pkg::CSR_IDX_W-1:0] idx,
                            logic [scvp_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         scvp_pkg::CSR_ACCEL_TICKS: accel_ticks_q = val[15:0];
         scvp_pkg::CSR_DECEL_TICKS: decel_ticks_q = val[15:0];
         scvp_pkg::CSR_TOLERANCE:   tol_q = val;
         scvp_pkg::CSR_YAW_SCALE:   yaw_scale_q = val[15:0];
         default: ;
      endcase
   endtask

   // Random upper bits on the 16-bit registers must be dropped by the block.
   task automatic apply_setting(ramp_setting_type s);
      write_reg(scvp_pkg::CSR_ACCEL_TICKS, {15'($urandom), s.accel});
      write_reg(scvp_pkg::CSR_DECEL_TICKS, {15'($urandom), s.decel});
      write_reg(scvp_pkg::CSR_TOLERANCE, s.tol);
      write_reg(scvp_pkg::CSR_YAW_SCALE, {15'($urandom), s.scale});
      @(posedge clock);
   endtask

   // Result side: compare at the accepting edge, then decide the next ready.
   int stall_left = 0;
   always @(posedge clock) begin
      vel_set_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (pending_vel.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: %h %h %h",
                           rsp_vel_x, rsp_vel_y, rsp_vel_yaw);
            end else begin
               want = pending_vel.pop_front();
               if (want.x !== rsp_vel_x || want.y !== rsp_vel_y
                   || want.yaw !== rsp_vel_yaw) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch #%0d: expected %h %h %h, got %h %h %h", checked,
                              want.x, want.y, want.yaw, rsp_vel_x, rsp_vel_y, rsp_vel_yaw);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                        : $urandom_range(1, 3);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("s_curve_velocity_planner regression: fail");
         $finish;
      end
   end

   directed_row_type rows[] = '{
      '{32'sd0, 32'sd0, 32'sd0, 1, 32'sd0, 32'sd0, 32'sd0},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1, 32'sd0, 32'sd0, 32'sd0},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0},
      '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0},
      '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0},
      '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0},
      '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0},
      '{32'sd655, -32'sd655, 32'sd656, 0, 0, 0, 0},
      '{32'sd655, -32'sd655, 32'sd656, 0, 0, 0, 0},
      '{32'h00010000, 32'hFFFF0000, 32'h00008000, 0, 0, 0, 0},
      '{32'h00010000, 32'hFFFF0000, 32'h00008000, 0, 0, 0, 0},
      '{32'sd0, 32'sd0, 32'sd0, 0, 0, 0, 0},
      '{32'sd0, 32'sd0, 32'sd0, 0, 0, 0, 0}
   };

   ramp_setting_type settings[] = '{
      '{16'd1, 16'd1, 31'd0, 16'd1},
      '{16'd0, 16'd0, 31'd655, 16'd0},
      '{16'd65535, 16'd65535, 31'h7FFFFFFF, 16'd65535},
      '{16'd3, 16'd7, 31'd1000, 16'd128},
      '{16'd200, 16'd2, 31'd40000, 16'd65535},
      '{16'd10, 16'd10, 31'd655, 16'd256}
   };

   initial begin
      vel_set_type      tgt, none;
      ramp_setting_type s;
      int               hold;
      none = '{0, 0, 0};
      reset_planner();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[k]) begin
         tgt = '{rows[k].x, rows[k].y, rows[k].yaw};
         send_targets(tgt, rows[k].typed, '{rows[k].ex, rows[k].ey, rows[k].eyaw});
      end

      for (int p = 0; p <= settings.size(); p++) begin
         req_valid <= 1'b0;
         drain();
         if (p < settings.size())
            s = settings[p];
         else
            s = '{16'($urandom_range(1, 30)), 16'($urandom_range(1, 30)),
                  31'($urandom), 16'($urandom_range(1, 1024))};
         apply_setting(s);
         calm = (p % 3 == 1);
         tgt = '{pick_target(), pick_target(), pick_target()};
         hold = 0;
         for (int n = 0; n < ITEMS_EACH - 20; n++) begin
            // Targets are mostly held for a while so ramps run to completion.
            if (hold == 0) begin
               hold = $urandom_range(1, 25);
               if ($urandom_range(0, 1)) tgt.x = pick_target();
               if ($urandom_range(0, 1)) tgt.y = pick_target();
               if ($urandom_range(0, 1)) tgt.yaw = pick_target();
            end
            hold--;
            if ($urandom_range(0, 19) == 0)
               send_targets('{pick_target(), pick_target(), pick_target()}, 0, none);
            else
               send_targets(tgt, 0, none);
         end
      end

      req_valid <= 1'b0;
      drain();
      $display("Covered %0d checked transactions over %0d register settings,",
               checked, settings.size() + 2);
      $display("including zero and maximum ramp times, zero and full-scale tolerance.");
      if (mismatches == 0)
         $display("s_curve_velocity_planner regression: pass");
      else
         $display("s_curve_velocity_planner regression: fail");
      $finish;
   end

endmodule
